// ----- hw/rtl/dq_pkg.sv -----
// Shared constants, codes and control structs for the front-end deque block.
// No dependencies; used by the interfaces, controller, datapath and top level.
package dq_pkg;

  localparam int unsigned DEPTH_DEF = 512;

  localparam int unsigned OP_W   = 2;
  localparam int unsigned DATA_W = 32;
  localparam int unsigned ST_W   = 2;
  localparam int unsigned IDX_W  = 9;
  localparam int unsigned CNT_W  = 10;

  // operation codes
  localparam logic [OP_W-1:0] OP_PUSH = 2'd0;
  localparam logic [OP_W-1:0] OP_POP  = 2'd1;
  localparam logic [OP_W-1:0] OP_FIND = 2'd2;

  // result status codes
  localparam logic [ST_W-1:0] ST_OK    = 2'd0;
  localparam logic [ST_W-1:0] ST_FULL  = 2'd1;
  localparam logic [ST_W-1:0] ST_EMPTY = 2'd2;

  // controller -> datapath commands
  typedef struct packed {
    logic take;     // input transfer: latch item, do push/pop state update
    logic pop_fix;  // refill second value from memory after a pop
    logic scan;     // find scan step
    logic load;     // copy result into the output register
  } dq_cmd_t;

  // datapath -> controller status
  typedef struct packed {
    logic empty;      // no stored values
    logic scan_done;  // find scan finishes this cycle
  } dq_sts_t;

endpackage

// ----- hw/rtl/dq_ifs.sv -----
// Valid/ready channel interfaces for the deque block's input and result sides.
// Depends on dq_pkg for field widths.
interface dq_in_if;
  logic                        valid;
  logic                        ready;
  logic [dq_pkg::OP_W-1:0]     op;
  logic signed [dq_pkg::DATA_W-1:0] value;

  modport source (output valid, output op, output value, input ready);
  modport sink   (input valid, input op, input value, output ready);
endinterface

interface dq_out_if;
  logic                              valid;
  logic                              ready;
  logic [dq_pkg::ST_W-1:0]           status;
  logic signed [dq_pkg::DATA_W-1:0]  popped_value;
  logic                              found;
  logic [dq_pkg::IDX_W-1:0]          found_index;
  logic signed [dq_pkg::DATA_W-1:0]  front_value;
  logic signed [dq_pkg::DATA_W-1:0]  second_value;
  logic [dq_pkg::CNT_W-1:0]          count;

  modport source (output valid, output status, output popped_value, output found,
                  output found_index, output front_value, output second_value,
                  output count, input ready);
  modport sink   (input valid, input status, input popped_value, input found,
                  input found_index, input front_value, input second_value,
                  input count, output ready);
endinterface

// ----- hw/rtl/dq_ctrl.sv -----
// Sequencing state machine for the deque: accepts items, steps pop refill and
// find scan, and owns the result valid flag. Depends on dq_pkg.
module dq_ctrl (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  input  logic [dq_pkg::OP_W-1:0] in_op,
  output logic                  in_ready,
  input  logic                  out_ready,
  output logic                  out_valid,
  input  dq_pkg::dq_sts_t       sts,
  output dq_pkg::dq_cmd_t       cmd
);
  import dq_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE  = 4'b0001,
    S_POPRD = 4'b0010,
    S_SCAN  = 4'b0100,
    S_LOAD  = 4'b1000
  } state_t;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;
  logic   take;

  assign in_ready  = (state_r == S_IDLE);
  assign take      = in_valid && in_ready;
  assign out_valid = out_valid_r;

  // next state and commands
  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    cmd.take  = take;
    unique case (state_r)
      S_IDLE: begin
        if (take) begin
          unique case (in_op)
            OP_POP:  state_nxt = sts.empty ? S_LOAD : S_POPRD;
            OP_FIND: state_nxt = sts.empty ? S_LOAD : S_SCAN;
            default: state_nxt = S_LOAD;
          endcase
        end
      end
      S_POPRD: begin
        cmd.pop_fix = 1'b1;
        state_nxt   = S_LOAD;
      end
      S_SCAN: begin
        cmd.scan = 1'b1;
        if (sts.scan_done) state_nxt = S_LOAD;
      end
      S_LOAD: begin
        // wait for the output register to free up
        if (!out_valid_r || out_ready) begin
          cmd.load  = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // result valid flag
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.load)       out_valid_nxt = 1'b1;
    else if (out_ready) out_valid_nxt = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

// ----- hw/rtl/dq_dp.sv -----
// Deque datapath: ring memory, head pointer, count, cached front/second values,
// find scan pipeline and result register. Depends on dq_pkg.
module dq_dp #(
  parameter int unsigned DEPTH = dq_pkg::DEPTH_DEF
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  dq_pkg::dq_cmd_t                  cmd,
  output dq_pkg::dq_sts_t                  sts,
  input  logic [dq_pkg::OP_W-1:0]          in_op,
  input  logic signed [dq_pkg::DATA_W-1:0] in_value,
  output logic [dq_pkg::ST_W-1:0]          out_status,
  output logic signed [dq_pkg::DATA_W-1:0] out_popped_value,
  output logic                             out_found,
  output logic [dq_pkg::IDX_W-1:0]         out_found_index,
  output logic signed [dq_pkg::DATA_W-1:0] out_front_value,
  output logic signed [dq_pkg::DATA_W-1:0] out_second_value,
  output logic [dq_pkg::CNT_W-1:0]         out_count
);
  import dq_pkg::*;

  localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);

  localparam logic [PW-1:0] PTR_LAST = PW'(DEPTH - 1);
  localparam logic [PW:0]   PTR_SPAN = (PW + 1)'(DEPTH);
  localparam logic [CW-1:0] CNT_FULL = CW'(DEPTH);

  // ring storage
  logic [DATA_W-1:0] mem [DEPTH];
  logic [DATA_W-1:0] rdata_r;
  logic [PW-1:0]     rd_addr;
  logic              we;

  // deque state
  logic [PW-1:0]     head_r, head_nxt;
  logic [CW-1:0]     cnt_r, cnt_nxt;
  logic [DATA_W-1:0] front_r, front_nxt;
  logic [DATA_W-1:0] second_r, second_nxt;

  // per-item working registers
  logic [ST_W-1:0]   status_r;
  logic [DATA_W-1:0] popped_r;
  logic [DATA_W-1:0] key_r;
  logic              found_r;
  logic [PW-1:0]     fidx_r;

  // scan pipeline
  logic [PW-1:0]     rptr_r;
  logic [CW-1:0]     iss_r;
  logic [CW-1:0]     cmp_idx_r;
  logic              cmp_vld_r;
  logic              hit;

  logic              is_push, is_pop, full, empty;
  logic [PW-1:0]     head_dec, head_inc, rptr_inc, pop_addr;
  logic [PW:0]       head_p2;

  assign full  = (cnt_r == CNT_FULL);
  assign empty = (cnt_r == '0);

  assign is_push = cmd.take && (in_op == OP_PUSH) && !full;
  assign is_pop  = cmd.take && (in_op == OP_POP) && !empty;

  // ring pointer arithmetic
  assign head_dec = (head_r == '0) ? PTR_LAST : head_r - PW'(1);
  assign head_inc = (head_r == PTR_LAST) ? '0 : head_r + PW'(1);
  assign rptr_inc = (rptr_r == PTR_LAST) ? '0 : rptr_r + PW'(1);
  assign head_p2  = {1'b0, head_r} + (PW + 1)'(2);
  assign pop_addr = (head_p2 >= PTR_SPAN) ? PW'(head_p2 - PTR_SPAN) : head_p2[PW-1:0];

  // pop reads the entry that becomes second; scan reads along the ring
  assign rd_addr = cmd.take ? pop_addr : rptr_r;
  assign we      = is_push;

  always_ff @(posedge clk) begin
    if (we) mem[head_dec] <= in_value;
    rdata_r <= mem[rd_addr];
  end

  // scan compare
  assign hit           = cmp_vld_r && (rdata_r == key_r);
  assign sts.scan_done = cmp_vld_r && (hit || (cmp_idx_r == cnt_r - CW'(1)));
  assign sts.empty     = empty;

  // deque state update
  always_comb begin
    head_nxt   = head_r;
    cnt_nxt    = cnt_r;
    front_nxt  = front_r;
    second_nxt = second_r;
    if (is_push) begin
      head_nxt   = head_dec;
      cnt_nxt    = cnt_r + CW'(1);
      front_nxt  = in_value;
      second_nxt = front_r;
    end else if (is_pop) begin
      head_nxt  = head_inc;
      cnt_nxt   = cnt_r - CW'(1);
      front_nxt = second_r;
    end else if (cmd.pop_fix) begin
      second_nxt = (cnt_r >= CW'(2)) ? rdata_r : '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r   <= '0;
      cnt_r    <= '0;
      front_r  <= '0;
      second_r <= '0;
    end else begin
      head_r   <= head_nxt;
      cnt_r    <= cnt_nxt;
      front_r  <= front_nxt;
      second_r <= second_nxt;
    end
  end

  // item latch and find scan
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cmp_vld_r <= 1'b0;
    end else if (cmd.take) begin
      cmp_vld_r <= 1'b0;
    end else if (cmd.scan) begin
      cmp_vld_r <= (iss_r < cnt_r);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.take) begin
      key_r    <= in_value;
      found_r  <= 1'b0;
      fidx_r   <= '0;
      popped_r <= is_pop ? front_r : '0;
      rptr_r   <= head_r;
      iss_r    <= '0;
      if ((in_op == OP_PUSH) && full)      status_r <= ST_FULL;
      else if ((in_op == OP_POP) && empty) status_r <= ST_EMPTY;
      else                                 status_r <= ST_OK;
    end else if (cmd.scan) begin
      rptr_r    <= rptr_inc;
      cmp_idx_r <= iss_r;
      if (iss_r < cnt_r) iss_r <= iss_r + CW'(1);
      if (hit) begin
        found_r <= 1'b1;
        fidx_r  <= cmp_idx_r[PW-1:0];
      end
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      out_status       <= status_r;
      out_popped_value <= popped_r;
      out_found        <= found_r;
      out_found_index  <= IDX_W'(fidx_r);
      out_front_value  <= front_r;
      out_second_value <= second_r;
      out_count        <= CNT_W'(cnt_r);
    end
  end

endmodule

// ----- hw/rtl/deque_front_ops_with_search.sv -----
// Top level of the front-end deque with search: controller plus datapath.
// Depends on dq_pkg, dq_ifs (dq_in_if, dq_out_if), dq_ctrl and dq_dp.
//
//  Channel | Dir | Handshake        | Payload
//  --------+-----+------------------+-----------------------------------------
//  in_ch   | in  | valid/ready      | op, value
//  out_ch  | out | valid/ready      | status, popped_value, found, found_index,
//          |     |                  | front_value, second_value, count
//
// Push and no-op go straight to the result load; pop adds a memory refill step
// (skipped on an empty deque), and find on an empty deque skips the scan. Find runs
// one ring read per cycle and stops at the first match or after the last value.
// One item is in work at a time; a new item is taken while the previous result
// still sits in the output register, and the new result waits there for it.
// Reset (rst_n low, synchronous) empties the deque; memory contents are not cleared.
module deque_front_ops_with_search #(
  parameter int unsigned DEPTH = dq_pkg::DEPTH_DEF
) (
  input logic      clk,
  input logic      rst_n,
  dq_in_if.sink    in_ch,
  dq_out_if.source out_ch
);
  import dq_pkg::*;

  dq_cmd_t cmd;
  dq_sts_t sts;

  dq_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_op     (in_ch.op),
    .in_ready  (in_ch.ready),
    .out_ready (out_ch.ready),
    .out_valid (out_ch.valid),
    .sts       (sts),
    .cmd       (cmd)
  );

  dq_dp #(
    .DEPTH (DEPTH)
  ) u_dp (
    .clk              (clk),
    .rst_n            (rst_n),
    .cmd              (cmd),
    .sts              (sts),
    .in_op            (in_ch.op),
    .in_value         (in_ch.value),
    .out_status       (out_ch.status),
    .out_popped_value (out_ch.popped_value),
    .out_found        (out_ch.found),
    .out_found_index  (out_ch.found_index),
    .out_front_value  (out_ch.front_value),
    .out_second_value (out_ch.second_value),
    .out_count        (out_ch.count)
  );

endmodule

// ----- test/tb_top.sv -----
// Self-checking testbench for deque_front_ops_with_search: push, pop and find at the front.
// Depends on dq_pkg and the dq_in_if / dq_out_if interfaces; predicts every result in SV.
// Directed, full-ring, backpressure and random tests share one sender and one result checker.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import dq_pkg::*;

  // op code 3 is unused by the block and acts as a no-op
  localparam logic [OP_W-1:0] OP_NOP = 2'd3;

  localparam int unsigned DEPTH        = DEPTH_DEF;
  localparam int unsigned RAND_ITEMS   = 720;
  localparam int unsigned LIMIT_CYCLES = 2_000_000;
  localparam int unsigned HOLD_CYCLES  = 300;

  typedef struct {
    logic [ST_W-1:0]          status;
    logic signed [DATA_W-1:0] popped_value;
    logic                     found;
    logic [IDX_W-1:0]         found_index;
    logic signed [DATA_W-1:0] front_value;
    logic signed [DATA_W-1:0] second_value;
    logic [CNT_W-1:0]         count;
  } dq_result_t;

  logic clk;
  logic rst_n;

  dq_in_if  in_ch ();
  dq_out_if out_ch ();

  deque_front_ops_with_search uut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  // predictor state: front of the deque is element 0
  logic signed [DATA_W-1:0] deque_model[$];
  dq_result_t               expected_q[$];

  int unsigned fail_count   = 0;
  int unsigned cycle_count  = 0;
  int unsigned stall_left   = 0;
  bit          send_idle_on = 1'b1;
  bit          recv_idle_on = 1'b1;

  // clock
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // run limit
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= LIMIT_CYCLES) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  // result side ready: random gaps, plus long hold-offs requested by a test
  always @(posedge clk) begin
    if (stall_left != 0) begin
      out_ch.ready <= 1'b0;
      stall_left = stall_left - 1;
    end else begin
      out_ch.ready <= !(recv_idle_on && $urandom_range(99) < 12);
    end
  end

  // work out the result of one accepted item and update the deque
  function automatic void predict_item(input logic [OP_W-1:0] op,
                                       input logic signed [DATA_W-1:0] val);
    dq_result_t r;
    r = '{default: '0};
    r.status = ST_OK;
    case (op)
      OP_PUSH: begin
        if (deque_model.size() >= DEPTH) r.status = ST_FULL;
        else deque_model.insert(0, val);
      end
      OP_POP: begin
        if (deque_model.size() == 0) begin
          r.status = ST_EMPTY;
        end else begin
          r.popped_value = deque_model[0];
          deque_model.delete(0);
        end
      end
      OP_FIND: begin
        for (int i = 0; i < deque_model.size(); i++) begin
          if (deque_model[i] == val) begin
            r.found       = 1'b1;
            r.found_index = IDX_W'(i);
            break;
          end
        end
      end
      default: ;
    endcase
    r.front_value  = (deque_model.size() >= 1) ? deque_model[0] : '0;
    r.second_value = (deque_model.size() >= 2) ? deque_model[1] : '0;
    r.count        = CNT_W'(deque_model.size());
    expected_q.push_back(r);
  endfunction

  // offer one item; called and returning at a rising edge, transfer at the final edge
  task automatic send_item(input logic [OP_W-1:0] op, input logic signed [DATA_W-1:0] val);
    while (send_idle_on && $urandom_range(99) < 12) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.op    <= op;
    in_ch.value <= val;
    // ready is stable mid-cycle; the transfer happens at the next edge
    @(negedge clk);
    while (!in_ch.ready) @(negedge clk);
    predict_item(op, val);
    @(posedge clk);
  endtask

  task automatic check_field(input string name, input logic [31:0] exp_v,
                             input logic [31:0] act_v);
    if (act_v !== exp_v) begin
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, exp_v, act_v);
      fail_count++;
    end
  endtask

  // compare every result transfer with the oldest prediction
  initial begin
    dq_result_t e;
    forever begin
      @(negedge clk);
      if (rst_n === 1'b1 && out_ch.valid === 1'b1 && out_ch.ready === 1'b1) begin
        if (expected_q.size() == 0) begin
          $display("%0t: result with none expected, expected nothing, actual count %0h",
                   $time, out_ch.count);
          fail_count++;
        end else begin
          e = expected_q[0];
          expected_q.delete(0);
          check_field("status",       32'(e.status),      32'(out_ch.status));
          check_field("popped_value", e.popped_value,     out_ch.popped_value);
          check_field("found",        32'(e.found),       32'(out_ch.found));
          check_field("found_index",  32'(e.found_index), 32'(out_ch.found_index));
          check_field("front_value",  e.front_value,      out_ch.front_value);
          check_field("second_value", e.second_value,     out_ch.second_value);
          check_field("count",        32'(e.count),       32'(out_ch.count));
        end
      end
    end
  end

  // values that repeat often, so finds meet duplicates and extremes
  function automatic logic signed [DATA_W-1:0] pool_value(input int unsigned idx);
    case (idx)
      0:       return 32'sh8000_0000;
      1:       return 32'sh7fff_ffff;
      2:       return 32'sh0000_0000;
      3:       return -32'sd1;
      4:       return 32'sh0000_0001;
      5:       return 32'sh5555_5555;
      6:       return 32'shaaaa_aaaa;
      default: return 32'sh0000_0002;
    endcase
  endfunction

  // find targets mostly hit stored values; pushes mix repeats and full random words
  function automatic logic signed [DATA_W-1:0] pick_value(input bit for_find);
    int unsigned roll;
    roll = $urandom_range(99);
    if (for_find && deque_model.size() != 0 && roll < 60)
      return deque_model[$urandom_range(deque_model.size() - 1)];
    if (roll < 35 || (for_find && roll < 80))
      return pool_value($urandom_range(7));
    return $urandom;
  endfunction

  // empty-deque cases, extremes, every op, hit and miss finds
  task automatic test_basic_ops();
    send_item(OP_FIND, 32'sd0);
    send_item(OP_POP,  32'sd0);
    send_item(OP_NOP,  32'sd0);
    send_item(OP_PUSH, 32'sh8000_0000);
    send_item(OP_PUSH, 32'sh7fff_ffff);
    send_item(OP_PUSH, 32'sd0);
    send_item(OP_PUSH, -32'sd1);
    send_item(OP_PUSH, 32'sh7fff_ffff);
    send_item(OP_FIND, 32'sh7fff_ffff);
    send_item(OP_FIND, 32'sh8000_0000);
    send_item(OP_FIND, -32'sd1);
    send_item(OP_FIND, 32'sd12345);
    send_item(OP_NOP,  -32'sd1);
    repeat (5) send_item(OP_POP, 32'sd0);
    send_item(OP_POP,  32'sd0);
    send_item(OP_FIND, 32'sd0);
  endtask

  // fill the ring, get a push refused, search the deepest slot, then drain
  task automatic test_full_deque();
    for (int i = 0; i < DEPTH; i++)
      send_item(OP_PUSH, {i[15:0], 16'($urandom)});
    send_item(OP_PUSH, 32'sh1234_5678);
    send_item(OP_FIND, deque_model[DEPTH-1]);
    send_item(OP_FIND, deque_model[0]);
    send_item(OP_FIND, 32'sh0000_ffff);
    send_item(OP_NOP,  32'sd0);
    repeat (DEPTH) send_item(OP_POP, 32'sd0);
    send_item(OP_POP, 32'sd0);
  endtask

  // receiver holds off while items keep coming, so the input stalls
  task automatic test_backpressure();
    stall_left = HOLD_CYCLES;
    repeat (30) begin
      case ($urandom_range(2))
        0:       send_item(OP_PUSH, pick_value(1'b0));
        1:       send_item(OP_FIND, pick_value(1'b1));
        default: send_item(OP_POP,  32'sd0);
      endcase
    end
  endtask

  // random walk of the fill level, one deep run to the full mark
  task automatic test_random_mix();
    int unsigned n_sent;
    int unsigned level_goal;
    int unsigned seg_len;
    int unsigned roll;
    int unsigned p_push;
    int unsigned p_pop;
    int unsigned p_find;
    bit          deep_done;
    logic [OP_W-1:0] op;
    n_sent    = 0;
    deep_done = 1'b0;
    while (n_sent < RAND_ITEMS) begin
      seg_len = $urandom_range(40, 120);
      if (!deep_done) begin
        level_goal = DEPTH;
        seg_len    = DEPTH + 120;
        deep_done  = 1'b1;
        // the deep run goes with no gaps on either side
        send_idle_on = 1'b0;
      end else begin
        level_goal = $urandom_range(0, 48);
        // some segments run with no gaps on either side
        send_idle_on = ($urandom_range(4) != 0);
      end
      recv_idle_on = send_idle_on;
      if (seg_len > RAND_ITEMS - n_sent) seg_len = RAND_ITEMS - n_sent;
      repeat (seg_len) begin
        roll = $urandom_range(99);
        if (level_goal == DEPTH) begin
          p_push = 92; p_pop = 94; p_find = 98;
        end else if (deque_model.size() < level_goal) begin
          p_push = 55; p_pop = 70; p_find = 95;
        end else begin
          p_push = 20; p_pop = 65; p_find = 95;
        end
        if (roll < p_push)      op = OP_PUSH;
        else if (roll < p_pop)  op = OP_POP;
        else if (roll < p_find) op = OP_FIND;
        else                    op = OP_NOP;
        send_item(op, pick_value(op == OP_FIND));
        n_sent++;
      end
    end
    send_idle_on = 1'b1;
    recv_idle_on = 1'b1;
  endtask

  // sequence
  initial begin
    rst_n        = 1'b0;
    in_ch.valid  = 1'b0;
    in_ch.op     = OP_PUSH;
    in_ch.value  = '0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_basic_ops();
    test_full_deque();
    test_backpressure();
    test_random_mix();
    in_ch.valid <= 1'b0;

    while (expected_q.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);

    if (fail_count == 0 && expected_q.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
